FILE: rtl/ximp_pkg.sv
// Shared types and constants for the x86 instruction pattern matcher.
// Holds the item structs, the instruction form codes and the opcode bytes.
// No dependencies.
package ximp_pkg;

    // Instruction form codes, in selector order
    typedef enum logic [4:0] {
        OP_ADD_IMM8     = 5'd0,
        OP_ADD_IMM32    = 5'd1,
        OP_CALL_REG     = 5'd2,
        OP_CALL_REL     = 5'd3,
        OP_CMP_IMM32    = 5'd4,
        OP_INC_REG      = 5'd5,
        OP_JMP_REL      = 5'd6,
        OP_MOV_REG      = 5'd7,
        OP_LEA_SIB      = 5'd8,
        OP_MOV_IMM8     = 5'd9,
        OP_MOV_IMM32    = 5'd10,
        OP_NOP          = 5'd11,
        OP_POP_REG      = 5'd12,
        OP_POPAD        = 5'd13,
        OP_PUSH_REG     = 5'd14,
        OP_PUSH_IMM8    = 5'd15,
        OP_PUSH_IMM32   = 5'd16,
        OP_PUSHAD       = 5'd17,
        OP_RETN         = 5'd18,
        OP_SETNZ        = 5'd19,
        OP_SETZ         = 5'd20,
        OP_SUB_REG      = 5'd21,
        OP_SUB_IMM8     = 5'd22,
        OP_SUB_IMM32    = 5'd23,
        OP_TEST_REG     = 5'd24,
        OP_XOR_REG      = 5'd25,
        OP_CALL_ANY     = 5'd26,
        OP_FSTP         = 5'd27,
        OP_JMP_IND_ANY  = 5'd28,
        OP_JMP_IND      = 5'd29
    } op_t;

    // Opcode and ModRM base bytes
    localparam logic [7:0] OPC_GRP1_IMM8  = 8'h83;
    localparam logic [7:0] OPC_GRP1_IMM32 = 8'h81;
    localparam logic [7:0] OPC_GRP5       = 8'hFF;
    localparam logic [7:0] OPC_CALL_REL   = 8'hE8;
    localparam logic [7:0] OPC_JMP_REL    = 8'hE9;
    localparam logic [7:0] OPC_INC        = 8'h40;
    localparam logic [7:0] OPC_MOV_RM     = 8'h8B;
    localparam logic [7:0] OPC_LEA        = 8'h8D;
    localparam logic [7:0] OPC_MOV_IMM8   = 8'hB0;
    localparam logic [7:0] OPC_MOV_IMM32  = 8'hB8;
    localparam logic [7:0] OPC_NOP        = 8'h90;
    localparam logic [7:0] OPC_POP        = 8'h58;
    localparam logic [7:0] OPC_POPAD      = 8'h61;
    localparam logic [7:0] OPC_PUSH       = 8'h50;
    localparam logic [7:0] OPC_PUSH_IMM8  = 8'h6A;
    localparam logic [7:0] OPC_PUSH_IMM32 = 8'h68;
    localparam logic [7:0] OPC_PUSHAD     = 8'h60;
    localparam logic [7:0] OPC_RETN       = 8'hC3;
    localparam logic [7:0] OPC_RETN_IMM   = 8'hC2;
    localparam logic [7:0] OPC_TWO_BYTE   = 8'h0F;
    localparam logic [7:0] OPC_SETNZ      = 8'h95;
    localparam logic [7:0] OPC_SETZ       = 8'h94;
    localparam logic [7:0] OPC_SUB_RM     = 8'h2B;
    localparam logic [7:0] OPC_TEST       = 8'h85;
    localparam logic [7:0] OPC_XOR_RM     = 8'h33;
    localparam logic [7:0] OPC_FPU_DD     = 8'hDD;
    localparam logic [7:0] MODRM_REG      = 8'hC0;
    localparam logic [7:0] MODRM_CALL     = 8'hD0;
    localparam logic [7:0] MODRM_CMP      = 8'hF8;
    localparam logic [7:0] MODRM_SUB      = 8'hE8;
    localparam logic [7:0] MODRM_FSTP     = 8'hD8;
    localparam logic [7:0] MODRM_DISP32   = 8'h25;
    localparam logic [7:0] MODRM_SIB_D8   = 8'h44;

    // Bytes of a relative branch past its own encoding
    localparam logic [31:0] REL_INSN_LEN  = 32'd5;
    // Trailing bytes left uncompared on the wildcard forms
    localparam logic [2:0]  WILD_BYTES    = 3'd4;

    typedef struct packed {
        logic [4:0]  operation;
        logic [2:0]  reg_a;
        logic [2:0]  reg_b;
        logic [2:0]  reg_index;
        logic [3:0]  scale;
        logic [31:0] imm;
        logic [31:0] code_address;
        logic [47:0] code_window;
    } in_item_t;

    typedef struct packed {
        logic        matched;
        logic [2:0]  length;
        logic [31:0] next_address;
        logic [31:0] found_target;
        logic        scale_warning;
    } out_item_t;

    // Expected encoding handed from the encoder to the checker
    typedef struct packed {
        logic [47:0] bytes;
        logic [2:0]  length;
        logic [2:0]  cmp_len;
        logic        known;
        logic        warn;
        logic        capture;
    } enc_t;

endpackage

FILE: rtl/ximp_encode.sv
// Builds the expected x86 encoding of one instruction form.
// Depends on ximp_pkg.
module ximp_encode (
    input  ximp_pkg::in_item_t item,
    output ximp_pkg::enc_t     enc
);
    import ximp_pkg::*;

    logic [31:0] rel;
    logic [15:0] ret_word;
    logic [7:0]  ra;
    logic [1:0]  sib_scale;
    logic        bad_scale;
    logic        wild;
    op_t         op;

    assign op       = op_t'(item.operation);
    assign ra       = {5'd0, item.reg_a};
    assign rel      = item.imm - item.code_address - REL_INSN_LEN;
    assign ret_word = {item.imm[13:0], 2'b00};

    // LEA scale to SIB scale bits; bad values fall back to scale 1
    always_comb
    begin
        bad_scale = 1'b0;
        unique case (item.scale)
            4'd1:    sib_scale = 2'd0;
            4'd2:    sib_scale = 2'd1;
            4'd4:    sib_scale = 2'd2;
            4'd8:    sib_scale = 2'd3;
            default:
            begin
                sib_scale = 2'd0;
                bad_scale = 1'b1;
            end
        endcase
    end

    // Expected bytes, first byte in the low bits
    always_comb
    begin
        enc         = '0;
        enc.known   = 1'b1;
        wild        = 1'b0;
        unique case (op)
            OP_ADD_IMM8, OP_SUB_IMM8:
            begin
                enc.bytes[7:0]   = OPC_GRP1_IMM8;
                enc.bytes[15:8]  = ((op == OP_ADD_IMM8) ? MODRM_REG : MODRM_SUB) | ra;
                enc.bytes[23:16] = item.imm[7:0];
                enc.length       = 3'd3;
            end
            OP_ADD_IMM32, OP_CMP_IMM32, OP_SUB_IMM32:
            begin
                enc.bytes[7:0]   = OPC_GRP1_IMM32;
                if (op == OP_ADD_IMM32)
                    enc.bytes[15:8] = MODRM_REG | ra;
                else if (op == OP_CMP_IMM32)
                    enc.bytes[15:8] = MODRM_CMP | ra;
                else
                    enc.bytes[15:8] = MODRM_SUB | ra;
                enc.bytes[47:16] = item.imm;
                enc.length       = 3'd6;
            end
            OP_CALL_REG:
            begin
                enc.bytes[15:0] = {MODRM_CALL | ra, OPC_GRP5};
                enc.length      = 3'd2;
            end
            OP_CALL_REL, OP_JMP_REL:
            begin
                enc.bytes[7:0]  = (op == OP_CALL_REL) ? OPC_CALL_REL : OPC_JMP_REL;
                enc.bytes[39:8] = rel;
                enc.length      = 3'd5;
            end
            OP_INC_REG:
            begin
                enc.bytes[7:0] = OPC_INC + ra;
                enc.length     = 3'd1;
            end
            OP_MOV_REG, OP_SUB_REG, OP_XOR_REG:
            begin
                if (op == OP_MOV_REG)
                    enc.bytes[7:0] = OPC_MOV_RM;
                else if (op == OP_SUB_REG)
                    enc.bytes[7:0] = OPC_SUB_RM;
                else
                    enc.bytes[7:0] = OPC_XOR_RM;
                enc.bytes[15:8] = {2'b11, item.reg_a, item.reg_b};
                enc.length      = 3'd2;
            end
            OP_LEA_SIB:
            begin
                enc.bytes[7:0]   = OPC_LEA;
                enc.bytes[15:8]  = MODRM_SIB_D8 | {2'b00, item.reg_a, 3'b000};
                enc.bytes[23:16] = {sib_scale, item.reg_index, item.reg_b};
                enc.bytes[31:24] = item.imm[7:0];
                enc.length       = 3'd4;
                enc.warn         = bad_scale;
            end
            OP_MOV_IMM8:
            begin
                enc.bytes[15:0] = {item.imm[7:0], OPC_MOV_IMM8 + ra};
                enc.length      = 3'd2;
            end
            OP_MOV_IMM32:
            begin
                enc.bytes[7:0]  = OPC_MOV_IMM32 + ra;
                enc.bytes[39:8] = item.imm;
                enc.length      = 3'd5;
            end
            OP_NOP:
            begin
                enc.bytes[7:0] = OPC_NOP;
                enc.length     = 3'd1;
            end
            OP_POP_REG:
            begin
                enc.bytes[7:0] = OPC_POP + ra;
                enc.length     = 3'd1;
            end
            OP_POPAD:
            begin
                enc.bytes[7:0] = OPC_POPAD;
                enc.length     = 3'd1;
            end
            OP_PUSH_REG:
            begin
                enc.bytes[7:0] = OPC_PUSH + ra;
                enc.length     = 3'd1;
            end
            OP_PUSH_IMM8:
            begin
                enc.bytes[15:0] = {item.imm[7:0], OPC_PUSH_IMM8};
                enc.length      = 3'd2;
            end
            OP_PUSH_IMM32:
            begin
                enc.bytes[7:0]  = OPC_PUSH_IMM32;
                enc.bytes[39:8] = item.imm;
                enc.length      = 3'd5;
            end
            OP_PUSHAD:
            begin
                enc.bytes[7:0] = OPC_PUSHAD;
                enc.length     = 3'd1;
            end
            OP_RETN:
            begin
                // Plain return when no stack arguments, else C2 with byte count
                if (item.imm == 32'd0)
                begin
                    enc.bytes[7:0] = OPC_RETN;
                    enc.length     = 3'd1;
                end
                else
                begin
                    enc.bytes[23:0] = {ret_word, OPC_RETN_IMM};
                    enc.length      = 3'd3;
                end
            end
            OP_SETNZ, OP_SETZ:
            begin
                enc.bytes[7:0]   = OPC_TWO_BYTE;
                enc.bytes[15:8]  = (op == OP_SETNZ) ? OPC_SETNZ : OPC_SETZ;
                enc.bytes[23:16] = MODRM_REG | ra;
                enc.length       = 3'd3;
            end
            OP_TEST_REG:
            begin
                enc.bytes[15:0] = {2'b11, item.reg_a, item.reg_a, OPC_TEST};
                enc.length      = 3'd2;
            end
            OP_CALL_ANY:
            begin
                enc.bytes[7:0] = OPC_CALL_REL;
                enc.length     = 3'd5;
                enc.capture    = 1'b1;
                wild           = 1'b1;
            end
            OP_FSTP:
            begin
                enc.bytes[15:0] = {MODRM_FSTP | ra, OPC_FPU_DD};
                enc.length      = 3'd2;
            end
            OP_JMP_IND_ANY, OP_JMP_IND:
            begin
                enc.bytes[15:0] = {MODRM_DISP32, OPC_GRP5};
                if (op == OP_JMP_IND)
                    enc.bytes[47:16] = item.imm;
                else
                    wild = 1'b1;
                enc.length = 3'd6;
            end
            default:
            begin
                // Unassigned selector codes never match
                enc.known  = 1'b0;
                enc.length = 3'd1;
            end
        endcase
        enc.cmp_len = wild ? (enc.length - WILD_BYTES) : enc.length;
    end

endmodule

FILE: rtl/ximp_check.sv
// Compares code bytes with the expected encoding and forms the result item.
// Depends on ximp_pkg.
module ximp_check (
    input  ximp_pkg::in_item_t  item,
    input  ximp_pkg::enc_t      enc,
    output ximp_pkg::out_item_t result
);
    import ximp_pkg::*;

    localparam int NBYTES = 6;

    logic [NBYTES-1:0] byte_ok;
    logic              matched;

    // Per-byte compare; bytes past the compared length always pass
    always_comb
    begin
        for (int k = 0; k < NBYTES; k++)
        begin
            byte_ok[k] = (3'(k) >= enc.cmp_len)
                      || (item.code_window[8*k +: 8] == enc.bytes[8*k +: 8]);
        end
    end

    assign matched = enc.known && (&byte_ok);

    // Result fields
    always_comb
    begin
        result.matched       = matched;
        result.length        = enc.length;
        result.next_address  = matched ? (item.code_address + {29'd0, enc.length})
                                       : item.code_address;
        result.found_target  = (enc.capture && matched)
                             ? (item.code_window[39:8] + item.code_address + REL_INSN_LEN)
                             : 32'd0;
        result.scale_warning = enc.warn;
    end

endmodule

FILE: rtl/x86_instruction_pattern_matcher.sv
// x86 instruction pattern matcher: input register, encode and compare, result register.
// An item is registered, then its result; one item per cycle sustained while out_ready is high.
// The decode, the 32-bit branch and address adds and the byte compare sit in one stage.
// Both stages advance when the stage ahead is empty or draining; no bubbles.
// Reset (rst_n low, asynchronous) empties both stages; payload is not cleared.
// Depends on ximp_pkg, ximp_encode, ximp_check.
module x86_instruction_pattern_matcher (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ximp_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output ximp_pkg::out_item_t out_data
);
    import ximp_pkg::*;

    logic      s1_valid_reg;
    in_item_t  s1_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;

    logic      out_open;
    logic      s1_open;
    enc_t      enc;
    out_item_t result;

    // Stage enables: each stage loads when its holder is empty or leaving
    assign out_open = !out_valid_reg || out_ready;
    assign s1_open  = !s1_valid_reg || out_open;
    assign in_ready = s1_open;

    ximp_encode u_encode (
        .item (s1_item_reg),
        .enc  (enc)
    );

    ximp_check u_check (
        .item   (s1_item_reg),
        .enc    (enc),
        .result (result)
    );

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_open)
                s1_valid_reg <= in_valid;
            if (out_open)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s1_open && in_valid)
            s1_item_reg <= in_data;
        if (out_open && s1_valid_reg)
            out_item_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

FILE: rtl/ximp_checker.sv
// Port-level checks for the x86 instruction pattern matcher, bound to the top level.
// Depends on ximp_pkg and x86_instruction_pattern_matcher.
module ximp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input ximp_pkg::out_item_t out_data
);
    import ximp_pkg::*;

    // A stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result item changed while stalled");

    // Encoding length is always one to six bytes
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.length >= 3'd1) && (out_data.length <= 3'd6))
        else $error("encoding length out of range");

    // A captured call target only comes from a matched five-byte call
    a_target_call: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.found_target != 32'd0)
            |-> out_data.matched && (out_data.length == 3'd5))
        else $error("call target without a matched call");

    // Scale warnings only come with the four-byte LEA form
    a_warn_lea: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.scale_warning |-> (out_data.length == 3'd4))
        else $error("scale warning on a non-LEA item");

endmodule

bind x86_instruction_pattern_matcher ximp_checker u_ximp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

FILE: sim/x86_instruction_pattern_matcher_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for x86_instruction_pattern_matcher.
// A directed table followed by random items with random idling on both sides.
// Item structs and form codes come from the package; the encoder predicts all but typed rows.
module x86_instruction_pattern_matcher_tb;
    import ximp_pkg::*;

    // Selector codes past the last form; the block must never match them
    localparam logic [4:0] SEL_SPARE_LO = 5'd30;
    localparam logic [4:0] SEL_SPARE_HI = 5'd31;
    localparam int RANDOM_ITEMS = 1300;
    localparam int SINK_HOLD_CYCLES = 40;

    typedef struct {
        in_item_t  item;
        bit        fill;
        bit        typed;
        out_item_t want;
    } dir_row_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    out_item_t pending_checks[$];
    dir_row_t  stim_table[$];
    int        mismatches;
    int        results_seen;
    int        matched_seen;
    int        warnings_seen;
    int        targets_seen;
    bit        steady;
    bit        choke_sink;

    x86_instruction_pattern_matcher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d results still pending", pending_checks.size());
        $display("x86_instruction_pattern_matcher: mismatch");
        $finish;
    end

    // Expected bytes of one form, first byte low; cmp_len leaves out wildcard bytes
    function automatic void encode_form(input in_item_t it, output logic [47:0] enc,
                                        output logic [2:0] len, output logic [2:0] cmp_len,
                                        output bit known, output bit warn);
        logic [7:0]  ra;
        logic [31:0] rel;
        logic [1:0]  sb;
        bit          bad_scale;
        ra = {5'd0, it.reg_a};
        rel = it.imm - it.code_address - 32'd5;
        enc = '0;
        known = 1'b1;
        bad_scale = 1'b0;
        case (it.scale)
            4'd1: sb = 2'd0;
            4'd2: sb = 2'd1;
            4'd4: sb = 2'd2;
            4'd8: sb = 2'd3;
            default:
            begin
                sb = 2'd0;
                bad_scale = 1'b1;
            end
        endcase
        warn = (it.operation == OP_LEA_SIB) && bad_scale;

        case (it.operation)
            OP_ADD_IMM8:    enc[23:0] = {it.imm[7:0], 8'hC0 | ra, 8'h83};
            OP_ADD_IMM32:   enc = {it.imm, 8'hC0 | ra, 8'h81};
            OP_CALL_REG:    enc[15:0] = {8'hD0 | ra, 8'hFF};
            OP_CALL_REL:    enc[39:0] = {rel, 8'hE8};
            OP_CMP_IMM32:   enc = {it.imm, 8'hF8 | ra, 8'h81};
            OP_INC_REG:     enc[7:0] = 8'h40 + ra;
            OP_JMP_REL:     enc[39:0] = {rel, 8'hE9};
            OP_MOV_REG:     enc[15:0] = {2'b11, it.reg_a, it.reg_b, 8'h8B};
            OP_LEA_SIB:     enc[31:0] = {it.imm[7:0], sb, it.reg_index, it.reg_b,
                                         2'b01, it.reg_a, 3'b100, 8'h8D};
            OP_MOV_IMM8:    enc[15:0] = {it.imm[7:0], 8'hB0 + ra};
            OP_MOV_IMM32:   enc[39:0] = {it.imm, 8'hB8 + ra};
            OP_NOP:         enc[7:0] = 8'h90;
            OP_POP_REG:     enc[7:0] = 8'h58 + ra;
            OP_POPAD:       enc[7:0] = 8'h61;
            OP_PUSH_REG:    enc[7:0] = 8'h50 + ra;
            OP_PUSH_IMM8:   enc[15:0] = {it.imm[7:0], 8'h6A};
            OP_PUSH_IMM32:  enc[39:0] = {it.imm, 8'h68};
            OP_PUSHAD:      enc[7:0] = 8'h60;
            // argument count becomes a byte count, kept to 16 bits
            OP_RETN:        enc[23:0] = (it.imm == 32'd0) ? 24'h0000C3
                                                          : {it.imm[13:0], 2'b00, 8'hC2};
            OP_SETNZ:       enc[23:0] = {8'hC0 | ra, 8'h95, 8'h0F};
            OP_SETZ:        enc[23:0] = {8'hC0 | ra, 8'h94, 8'h0F};
            OP_SUB_REG:     enc[15:0] = {2'b11, it.reg_a, it.reg_b, 8'h2B};
            OP_SUB_IMM8:    enc[23:0] = {it.imm[7:0], 8'hE8 | ra, 8'h83};
            OP_SUB_IMM32:   enc = {it.imm, 8'hE8 | ra, 8'h81};
            OP_TEST_REG:    enc[15:0] = {2'b11, it.reg_a, it.reg_a, 8'h85};
            OP_XOR_REG:     enc[15:0] = {2'b11, it.reg_a, it.reg_b, 8'h33};
            OP_CALL_ANY:    enc[7:0] = 8'hE8;
            OP_FSTP:        enc[15:0] = {8'hD8 | ra, 8'hDD};
            OP_JMP_IND_ANY: enc[15:0] = {8'h25, 8'hFF};
            OP_JMP_IND:     enc = {it.imm, 8'h25, 8'hFF};
            default:        known = 1'b0;
        endcase

        case (it.operation)
            OP_CALL_REG, OP_MOV_REG, OP_MOV_IMM8, OP_PUSH_IMM8, OP_SUB_REG, OP_TEST_REG,
            OP_XOR_REG, OP_FSTP:
                len = 3'd2;
            OP_ADD_IMM8, OP_SETNZ, OP_SETZ, OP_SUB_IMM8:
                len = 3'd3;
            OP_LEA_SIB:
                len = 3'd4;
            OP_CALL_REL, OP_JMP_REL, OP_MOV_IMM32, OP_PUSH_IMM32, OP_CALL_ANY:
                len = 3'd5;
            OP_ADD_IMM32, OP_CMP_IMM32, OP_SUB_IMM32, OP_JMP_IND_ANY, OP_JMP_IND:
                len = 3'd6;
            OP_RETN:
                len = (it.imm == 32'd0) ? 3'd1 : 3'd3;
            default:
                len = 3'd1;
        endcase
        // wildcard forms skip their trailing dword
        cmp_len = (it.operation == OP_CALL_ANY || it.operation == OP_JMP_IND_ANY)
                  ? len - 3'd4 : len;
    endfunction

    function automatic logic [47:0] byte_mask(input logic [2:0] nbytes);
        logic [47:0] m;
        m = '0;
        for (int k = 0; k < nbytes; k++)
            m[8*k +: 8] = 8'hFF;
        return m;
    endfunction

    function automatic out_item_t predict_check(input in_item_t it);
        out_item_t   r;
        logic [47:0] enc;
        logic [2:0]  len;
        logic [2:0]  cmp_len;
        bit          known;
        bit          warn;
        encode_form(it, enc, len, cmp_len, known, warn);
        r.matched = known && (((it.code_window ^ enc) & byte_mask(cmp_len)) == 48'd0);
        r.length = len;
        r.next_address = r.matched ? it.code_address + {29'd0, len} : it.code_address;
        r.found_target = (it.operation == OP_CALL_ANY && r.matched)
                         ? it.code_window[39:8] + it.code_address + 32'd5 : 32'd0;
        r.scale_warning = warn;
        return r;
    endfunction

    // Writes the expected bytes into the window; optionally spoils one compared byte
    function automatic in_item_t fill_encoding(input in_item_t it, input bit spoil);
        logic [47:0] enc;
        logic [47:0] m;
        logic [2:0]  len;
        logic [2:0]  cmp_len;
        bit          known;
        bit          warn;
        int unsigned k;
        encode_form(it, enc, len, cmp_len, known, warn);
        m = byte_mask(cmp_len);
        it.code_window = (it.code_window & ~m) | (enc & m);
        if (spoil)
        begin
            k = $urandom_range(0, cmp_len - 1);
            it.code_window[8*k +: 8] = it.code_window[8*k +: 8] ^ 8'($urandom_range(1, 255));
        end
        return it;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        int unsigned pick;
        it.operation = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(30, 31))
                                                    : 5'($urandom_range(0, 29));
        it.reg_a = 3'($urandom_range(0, 7));
        it.reg_b = 3'($urandom_range(0, 7));
        it.reg_index = 3'($urandom_range(0, 7));
        it.scale = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'(1 << $urandom_range(0, 3));
        it.code_address = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 7)
                                                      : 32'($urandom);
        case ($urandom_range(0, 3))
            0: it.imm = $urandom;
            1: it.imm = $urandom_range(0, 255);
            2: it.imm = 32'hFFFF_FFFF - $urandom_range(0, 255);
            default: it.imm = it.code_address + $urandom_range(0, 511) - 32'd256;
        endcase
        it.code_window[47:32] = 16'($urandom);
        it.code_window[31:0] = $urandom;
        // mostly real encodings, a share of them with one byte spoiled
        pick = $urandom_range(0, 9);
        if (pick < 7)
            it = fill_encoding(it, pick < 2);
        return it;
    endfunction

    task automatic add_row(input logic [4:0] op, input logic [2:0] a, input logic [2:0] b,
                           input logic [2:0] ix, input logic [3:0] sc, input logic [31:0] imm,
                           input logic [31:0] addr, input logic [47:0] win, input bit fill);
        dir_row_t row;
        row.item = {op, a, b, ix, sc, imm, addr, win};
        row.fill = fill;
        row.typed = 1'b0;
        row.want = '0;
        stim_table.push_back(row);
    endtask

    // Row whose result is written out by hand
    task automatic add_known_row(input logic [4:0] op, input logic [2:0] a,
                                 input logic [31:0] imm, input logic [31:0] addr,
                                 input logic [47:0] win, input logic m, input logic [2:0] len,
                                 input logic [31:0] nxt, input logic [31:0] tgt,
                                 input logic w, input logic [3:0] sc = 4'd1,
                                 input logic [2:0] ix = 3'd4);
        dir_row_t row;
        row.item = {op, a, 3'd0, ix, sc, imm, addr, win};
        row.fill = 1'b0;
        row.typed = 1'b1;
        row.want = {m, len, nxt, tgt, w};
        stim_table.push_back(row);
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%t: result %0d %s: got %h, want %h", $realtime, results_seen, what, got, want);
        mismatches++;
    endtask

    // Offer one item after a random gap; the expectation is queued at acceptance
    task automatic send_item(input in_item_t it, input out_item_t want);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (!in_ready);
        pending_checks.push_back(want);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_checks.size() != 0) @(posedge clk);
    endtask

    // Result side: random stalls, one long hold-off on request
    initial
    begin : result_sink
        int gap;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = steady ? 0 : $urandom_range(0, 5);
            if (choke_sink)
            begin
                gap = SINK_HOLD_CYCLES;
                choke_sink = 1'b0;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_checks.size() == 0)
                note_mismatch("arrived with nothing pending", 32'd0, 32'd0);
            else
            begin
                want = pending_checks.pop_front();
                if (out_data.matched !== want.matched)
                    note_mismatch("matched", out_data.matched, want.matched);
                if (out_data.length !== want.length)
                    note_mismatch("length", out_data.length, want.length);
                if (out_data.next_address !== want.next_address)
                    note_mismatch("next_address", out_data.next_address, want.next_address);
                if (out_data.found_target !== want.found_target)
                    note_mismatch("found_target", out_data.found_target, want.found_target);
                if (out_data.scale_warning !== want.scale_warning)
                    note_mismatch("scale_warning", out_data.scale_warning, want.scale_warning);
                matched_seen += want.matched;
                warnings_seen += want.scale_warning;
                targets_seen += (want.found_target != 32'd0);
            end
            results_seen++;
        end
    end

    initial
    begin : stimulus
        in_item_t it;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        mismatches = 0;
        results_seen = 0;
        matched_seen = 0;
        warnings_seen = 0;
        targets_seen = 0;
        steady = 1'b0;
        choke_sink = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: address wrap, spare selectors, scale handling, wildcards, RETN
        add_known_row(OP_NOP, 3'd0, 32'd0, 32'd0, 48'h90, 1'b1, 3'd1, 32'd1, 32'd0, 1'b0);
        add_known_row(OP_NOP, 3'd0, 32'd0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FF90,
                      1'b1, 3'd1, 32'd0, 32'd0, 1'b0);
        add_known_row(SEL_SPARE_HI, 3'd7, 32'hFFFF_FFFF, 32'h0000_5678, 48'd0,
                      1'b0, 3'd1, 32'h0000_5678, 32'd0, 1'b0);
        add_known_row(SEL_SPARE_LO, 3'd0, 32'd0, 32'h0000_1234, 48'hFFFF_FFFF_FFFF,
                      1'b0, 3'd1, 32'h0000_1234, 32'd0, 1'b0);
        add_known_row(OP_LEA_SIB, 3'd0, 32'h12, 32'h100, 48'h0000_1220_448D,
                      1'b1, 3'd4, 32'h104, 32'd0, 1'b1, 4'd0, 3'd4);
        add_row(OP_LEA_SIB, 3'd7, 3'd7, 3'd7, 4'd8, 32'hFF, 32'h4000, 48'd0, 1'b1);
        add_row(OP_LEA_SIB, 3'd3, 3'd5, 3'd2, 4'd15, 32'h80, 32'h4010, 48'd0, 1'b1);
        add_row(OP_LEA_SIB, 3'd1, 3'd4, 3'd0, 4'd2, 32'h7F, 32'h4020, 48'd0, 1'b1);
        add_known_row(OP_CALL_ANY, 3'd0, 32'd0, 32'h1000, 48'h00FF_FFFF_FFE8,
                      1'b1, 3'd5, 32'h1005, 32'h1004, 1'b0);
        add_known_row(OP_CALL_ANY, 3'd0, 32'd0, 32'h1000, 48'h00FF_FFFF_FFE9,
                      1'b0, 3'd5, 32'h1000, 32'd0, 1'b0);
        add_row(OP_CALL_REL, 3'd0, 3'd0, 3'd0, 4'd1, 32'd0, 32'hFFFF_FFFE, 48'd0, 1'b1);
        add_row(OP_JMP_REL, 3'd0, 3'd0, 3'd0, 4'd1, 32'hFFFF_FFFF, 32'd0, 48'd0, 1'b1);
        add_row(OP_JMP_IND_ANY, 3'd0, 3'd0, 3'd0, 4'd1, 32'd0, 32'h2000,
                48'hFFFF_FFFF_FFFF, 1'b1);
        add_row(OP_JMP_IND, 3'd0, 3'd0, 3'd0, 4'd1, 32'hFFFF_FFFF, 32'h2010, 48'd0, 1'b1);
        add_known_row(OP_RETN, 3'd0, 32'd0, 32'h10, 48'hC3, 1'b1, 3'd1, 32'h11, 32'd0, 1'b0);
        add_known_row(OP_RETN, 3'd0, 32'h4000_0000, 32'h10, 48'hC2,
                      1'b1, 3'd3, 32'h13, 32'd0, 1'b0);
        add_row(OP_RETN, 3'd0, 3'd0, 3'd0, 4'd1, 32'hFFFF_FFFF, 32'h20, 48'd0, 1'b1);
        add_row(OP_SETNZ, 3'd7, 3'd0, 3'd0, 4'd1, 32'd0, 32'h30, 48'd0, 1'b1);
        add_row(OP_SETZ, 3'd0, 3'd0, 3'd0, 4'd1, 32'd0, 32'h40, 48'hFFFF_FFFF_FFFF, 1'b1);
        add_known_row(OP_TEST_REG, 3'd7, 32'd0, 32'h2000, 48'hFFFF_FFFF_FFFF,
                      1'b0, 3'd2, 32'h2000, 32'd0, 1'b0);
        add_row(OP_ADD_IMM32, 3'd7, 3'd0, 3'd0, 4'd1, 32'hFFFF_FFFF, 32'h50, 48'd0, 1'b1);
        add_row(OP_MOV_IMM32, 3'd0, 3'd0, 3'd0, 4'd1, 32'd0, 32'hFFFF_FFFB, 48'd0, 1'b1);
        add_row(OP_FSTP, 3'd7, 3'd0, 3'd0, 4'd1, 32'd0, 32'h60, 48'd0, 1'b1);
        add_row(OP_PUSH_IMM8, 3'd0, 3'd0, 3'd0, 4'd1, 32'h80, 32'h70, 48'd0, 1'b1);
        add_row(OP_CALL_REG, 3'd7, 3'd0, 3'd0, 4'd1, 32'd0, 32'h80, 48'd0, 1'b1);

        foreach (stim_table[i])
        begin
            it = stim_table[i].fill ? fill_encoding(stim_table[i].item, 1'b0)
                                    : stim_table[i].item;
            send_item(it, stim_table[i].typed ? stim_table[i].want : predict_check(it));
        end
        wait_for_results();

        // Random: one long result stall, a stretch with no idling, one full drain
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 300)
                choke_sink = 1'b1;
            steady = (i >= 600 && i < 800);
            if (i == 1000)
                wait_for_results();
            it = random_item();
            send_item(it, predict_check(it));
        end
        wait_for_results();
        repeat (8) @(posedge clk);

        $display("%0d results checked over all forms and spare selectors:", results_seen);
        $display("  %0d matched, %0d scale warnings, %0d call targets captured",
                 matched_seen, warnings_seen, targets_seen);
        if (mismatches == 0)
            $display("x86_instruction_pattern_matcher: match");
        else
            $display("x86_instruction_pattern_matcher: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ximp_pkg.sv
rtl/ximp_encode.sv
rtl/ximp_check.sv
rtl/x86_instruction_pattern_matcher.sv
rtl/ximp_checker.sv
sim/x86_instruction_pattern_matcher_tb.sv
